/* design/lpmf_pkg.sv */
// Shared widths, item kinds, status codes and write modes of the message FIFO.
package lpmf_pkg;

   localparam int KIND_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 16;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 10;
   localparam int COUNT_W  = 9;
   localparam int MODE_W   = 2;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [MODE_W-1:0]   mode_type;

   localparam kind_type KIND_BEGIN = 3'd0;
   localparam kind_type KIND_WRITE = 3'd1;
   localparam kind_type KIND_READ  = 3'd2;
   localparam kind_type KIND_PEEK  = 3'd3;
   localparam kind_type KIND_FLUSH = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   localparam mode_type MODE_IDLE = 2'd0;
   localparam mode_type MODE_FILL = 2'd1;
   localparam mode_type MODE_DROP = 2'd2;

endpackage

/* design/length_prefixed_message_fifo.sv */
// Length-prefixed message FIFO built around a one-port byte ring memory.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ------------------------------
//   request  req_kind, req_data_byte, req_msg_length  taken when start && !busy
//   result   rsp_status ... rsp_message_count         one cycle, marked by rsp_valid
//
// One result per request, valid for one cycle after the request's last cycle. Flush, write
// byte, rejected begin write, empty read or peek and unused kinds end in the cycle taken; an
// accepted begin writes the high header byte, then the low in S_WR_LO. A read or peek ends
// in S_DATA, after S_HDR_HI and S_HDR_LO when starting a message (S_HDR_LO if of length 0), as
// the one-port ring with registered reads must first deliver both header bytes. Busy is high
// outside S_IDLE. Sync reset clears state, pointers, rsp_valid. The receiver cannot stall.
module length_prefixed_message_fifo #(
   parameter int RING_BYTES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lpmf_pkg::KIND_W-1:0]         req_kind,
   input  logic [lpmf_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic [lpmf_pkg::LEN_W-1:0]          req_msg_length,
   output logic                                rsp_valid,
   output logic [lpmf_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lpmf_pkg::BYTE_W-1:0]         rsp_byte_out,
   output logic [lpmf_pkg::LEN_W-1:0]          rsp_length_out,
   output logic                                rsp_end_of_message,
   output logic [lpmf_pkg::USED_W-1:0]         rsp_used_bytes,
   output logic [lpmf_pkg::USED_W-1:0]         rsp_free_bytes,
   output logic [lpmf_pkg::COUNT_W-1:0]        rsp_message_count
);
   import lpmf_pkg::*;

   localparam int PTR_W = $clog2(RING_BYTES);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WR_LO  = 3'd1;  // write the low header byte
   localparam logic [2:0] S_HDR_HI = 3'd2;  // high header byte arrives
   localparam logic [2:0] S_HDR_LO = 3'd3;  // low header byte arrives
   localparam logic [2:0] S_DATA   = 3'd4;  // payload byte arrives

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] fill(input logic [PTR_W-1:0] tail,
                                              input logic [PTR_W-1:0] head);
      if (tail >= head) begin
         fill = tail - head;
      end else begin
         fill = PTR_W'({1'b0, tail} + (PTR_W+1)'(RING_BYTES) - {1'b0, head});
      end
   endfunction

   // The ring itself, one port, registered read data.
   logic [BYTE_W-1:0] ring_mem [RING_BYTES];
   logic [PTR_W-1:0]  mem_addr;
   logic              mem_we;
   logic [BYTE_W-1:0] mem_wdata;
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= ring_mem[mem_addr];
   end

   // Control and pointer state.
   logic [2:0]        state_ff, state_in;
   logic              is_peek_ff, is_peek_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [BYTE_W-1:0] hdr_hi_ff, hdr_hi_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]  wrem_ff, wrem_in;
   mode_type          wmode_ff, wmode_in;
   logic [PTR_W-1:0]  msgs_ff, msgs_in;
   logic [LEN_W-1:0]  rrem_ff, rrem_in;
   logic              ract_ff, ract_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;
   logic [PTR_W-1:0]  pcur_ff, pcur_in;
   logic [LEN_W-1:0]  prem_ff, prem_in;
   logic              pact_ff, pact_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;

   // Result of the request that finishes this cycle.
   logic              done;
   status_type        res_status;
   logic [BYTE_W-1:0] res_byte;
   logic [LEN_W-1:0]  res_length;
   logic              res_eom;

   logic              accept;
   logic [PTR_W-1:0]  used_now;
   logic [LEN_W:0]    need_bytes;
   logic [LEN_W:0]    free_now;
   logic [LEN_W-1:0]  hdr_len;
   logic [LEN_W-1:0]  rem_next;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      used_now   = fill(tail_ff, head_ff);
      free_now   = (LEN_W+1)'(PTR_W'(RING_BYTES - 1) - used_now);
      need_bytes = {1'b0, req_msg_length} + (LEN_W+1)'(2);
      hdr_len    = {hdr_hi_ff, rd_data_ff};
      rem_next   = rem_ff - 1'b1;

      state_in   = state_ff;
      is_peek_in = is_peek_ff;
      addr_in    = addr_ff;
      hdr_hi_in  = hdr_hi_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      wp_in      = wp_ff;
      wrem_in    = wrem_ff;
      wmode_in   = wmode_ff;
      msgs_in    = msgs_ff;
      rrem_in    = rrem_ff;
      ract_in    = ract_ff;
      rlen_in    = rlen_ff;
      pcur_in    = pcur_ff;
      prem_in    = prem_ff;
      pact_in    = pact_ff;
      plen_in    = plen_ff;

      mem_addr   = addr_ff;
      mem_we     = 1'b0;
      mem_wdata  = '0;

      done       = 1'b0;
      res_status = ST_OK;
      res_byte   = '0;
      res_length = '0;
      res_eom    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_BEGIN: begin
                     wp_in   = tail_ff;
                     wrem_in = req_msg_length;
                     if (need_bytes > free_now) begin
                        done       = 1'b1;
                        res_status = ST_FULL;
                        wmode_in   = (req_msg_length == '0) ? MODE_IDLE : MODE_DROP;
                     end else begin
                        mem_addr  = tail_ff;
                        mem_we    = 1'b1;
                        mem_wdata = req_msg_length[LEN_W-1:BYTE_W];
                        addr_in   = tail_ff;
                        len_in    = req_msg_length;
                        state_in  = S_WR_LO;
                     end
                  end
                  KIND_WRITE: begin
                     done = 1'b1;
                     if (wmode_ff == MODE_FILL) begin
                        mem_addr  = wp_ff;
                        mem_we    = 1'b1;
                        mem_wdata = req_data_byte;
                        wp_in     = bump(wp_ff);
                        wrem_in   = wrem_ff - 1'b1;
                        if (wrem_ff == LEN_W'(1)) begin
                           tail_in  = bump(wp_ff);
                           msgs_in  = msgs_ff + 1'b1;
                           wmode_in = MODE_IDLE;
                        end
                     end else begin
                        res_status = ST_FULL;
                        if (wmode_ff == MODE_DROP) begin
                           wrem_in = wrem_ff - 1'b1;
                           if (wrem_ff == LEN_W'(1)) begin
                              wmode_in = MODE_IDLE;
                           end
                        end
                     end
                  end
                  KIND_READ: begin
                     pact_in    = 1'b0;
                     is_peek_in = 1'b0;
                     if (!ract_ff && msgs_ff == '0) begin
                        done       = 1'b1;
                        res_status = ST_EMPTY;
                     end else begin
                        mem_addr = head_ff;
                        addr_in  = head_ff;
                        len_in   = rlen_ff;
                        rem_in   = rrem_ff;
                        state_in = ract_ff ? S_DATA : S_HDR_HI;
                     end
                  end
                  KIND_PEEK: begin
                     is_peek_in = 1'b1;
                     if (!pact_ff && !ract_ff && msgs_ff == '0) begin
                        done       = 1'b1;
                        res_status = ST_EMPTY;
                     end else if (pact_ff) begin
                        mem_addr = pcur_ff;
                        addr_in  = pcur_ff;
                        len_in   = plen_ff;
                        rem_in   = prem_ff;
                        state_in = S_DATA;
                     end else begin
                        // A peek during a read walks the unread rest of it.
                        mem_addr = head_ff;
                        addr_in  = head_ff;
                        len_in   = rlen_ff;
                        rem_in   = rrem_ff;
                        state_in = ract_ff ? S_DATA : S_HDR_HI;
                     end
                  end
                  KIND_FLUSH: begin
                     done     = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     wp_in    = '0;
                     wrem_in  = '0;
                     wmode_in = MODE_IDLE;
                     msgs_in  = '0;
                     rrem_in  = '0;
                     ract_in  = 1'b0;
                     rlen_in  = '0;
                     pcur_in  = '0;
                     prem_in  = '0;
                     pact_in  = 1'b0;
                     plen_in  = '0;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_WR_LO: begin
            done      = 1'b1;
            mem_addr  = bump(addr_ff);
            mem_we    = 1'b1;
            mem_wdata = len_ff[BYTE_W-1:0];
            wp_in     = bump(bump(addr_ff));
            wrem_in   = len_ff;
            state_in  = S_IDLE;
            if (len_ff == '0) begin
               tail_in  = bump(bump(addr_ff));
               msgs_in  = msgs_ff + 1'b1;
               wmode_in = MODE_IDLE;
            end else begin
               wmode_in = MODE_FILL;
            end
         end
         S_HDR_HI: begin
            hdr_hi_in = rd_data_ff;
            mem_addr  = bump(addr_ff);
            addr_in   = bump(addr_ff);
            state_in  = S_HDR_LO;
         end
         S_HDR_LO: begin
            // Fetch the first payload byte on speculation; it is used only
            // when the length turns out nonzero.
            mem_addr = bump(addr_ff);
            addr_in  = bump(addr_ff);
            len_in   = hdr_len;
            rem_in   = hdr_len;
            if (hdr_len == '0) begin
               done       = 1'b1;
               res_eom    = 1'b1;
               state_in   = S_IDLE;
               if (is_peek_ff) begin
                  plen_in = '0;
                  prem_in = '0;
                  pcur_in = bump(addr_ff);
                  pact_in = 1'b0;
               end else begin
                  rlen_in = '0;
                  rrem_in = '0;
                  head_in = bump(addr_ff);
                  ract_in = 1'b0;
                  msgs_in = msgs_ff - 1'b1;
               end
            end else begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            done       = 1'b1;
            res_byte   = rd_data_ff;
            res_length = len_ff;
            res_eom    = (rem_next == '0);
            state_in   = S_IDLE;
            if (is_peek_ff) begin
               plen_in = len_ff;
               prem_in = rem_next;
               pcur_in = bump(addr_ff);
               pact_in = (rem_next != '0);
            end else begin
               rlen_in = len_ff;
               rrem_in = rem_next;
               head_in = bump(addr_ff);
               ract_in = (rem_next != '0);
               if (rem_next == '0) begin
                  msgs_in = msgs_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Occupancy after the request, cut to the width of the result fields.
   logic [PTR_W-1:0]         used_after;
   logic [PTR_W+USED_W-1:0]  used_ext;
   logic [PTR_W+USED_W-1:0]  free_ext;
   logic [PTR_W+COUNT_W-1:0] count_ext;

   always_comb begin
      used_after = fill(tail_in, head_in);
      used_ext   = (PTR_W+USED_W)'(used_after);
      free_ext   = (PTR_W+USED_W)'(PTR_W'(RING_BYTES - 1) - used_after);
      count_ext  = (PTR_W+COUNT_W)'(msgs_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         wp_ff     <= '0;
         wrem_ff   <= '0;
         wmode_ff  <= MODE_IDLE;
         msgs_ff   <= '0;
         rrem_ff   <= '0;
         ract_ff   <= 1'b0;
         rlen_ff   <= '0;
         pcur_ff   <= '0;
         prem_ff   <= '0;
         pact_ff   <= 1'b0;
         plen_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         wp_ff     <= wp_in;
         wrem_ff   <= wrem_in;
         wmode_ff  <= wmode_in;
         msgs_ff   <= msgs_in;
         rrem_ff   <= rrem_in;
         ract_ff   <= ract_in;
         rlen_ff   <= rlen_in;
         pcur_ff   <= pcur_in;
         prem_ff   <= prem_in;
         pact_ff   <= pact_in;
         plen_ff   <= plen_in;
         rsp_valid <= done;
      end
   end

   // Working registers and result payload need no reset.
   always_ff @(posedge clock) begin
      is_peek_ff <= is_peek_in;
      addr_ff    <= addr_in;
      hdr_hi_ff  <= hdr_hi_in;
      len_ff     <= len_in;
      rem_ff     <= rem_in;
      if (done) begin
         rsp_status         <= res_status;
         rsp_byte_out       <= res_byte;
         rsp_length_out     <= res_length;
         rsp_end_of_message <= res_eom;
         rsp_used_bytes     <= used_ext[USED_W-1:0];
         rsp_free_bytes     <= free_ext[USED_W-1:0];
         rsp_message_count  <= count_ext[COUNT_W-1:0];
      end
   end

endmodule

/* tb/length_prefixed_message_fifo_check.sv */
// Checker that predicts every result of the message FIFO and compares it with the block.
`timescale 1ns / 1ps
module length_prefixed_message_fifo_check #(
   parameter int RING_BYTES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [lpmf_pkg::KIND_W-1:0]   req_kind,
   input  logic [lpmf_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [lpmf_pkg::LEN_W-1:0]    req_msg_length,
   input  logic                          rsp_valid,
   input  logic [lpmf_pkg::STATUS_W-1:0] rsp_status,
   input  logic [lpmf_pkg::BYTE_W-1:0]   rsp_byte_out,
   input  logic [lpmf_pkg::LEN_W-1:0]    rsp_length_out,
   input  logic                          rsp_end_of_message,
   input  logic [lpmf_pkg::USED_W-1:0]   rsp_used_bytes,
   input  logic [lpmf_pkg::USED_W-1:0]   rsp_free_bytes,
   input  logic [lpmf_pkg::COUNT_W-1:0]  rsp_message_count,
   output int                            failures,
   output int                            outstanding,
   output int                            results_checked,
   output int                            rejects_seen,
   output int                            peak_used
);
   import lpmf_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  byte_out;
      logic [LEN_W-1:0]   length;
      logic               eom;
      logic [USED_W-1:0]  used;
      logic [USED_W-1:0]  free;
      logic [COUNT_W-1:0] count;
   } fifo_report_type;

   // Pointers are USED_W bits wide, so they wrap at the ring size on their own.
   logic [BYTE_W-1:0] ring_copy [RING_BYTES];
   logic [USED_W-1:0] head_ptr, tail_ptr, fill_ptr, peek_ptr;
   logic [LEN_W-1:0]  fill_left, read_left, read_len, peek_left, peek_len;
   mode_type          fill_mode;
   logic              reading, peeking;
   int                stored_total;

   fifo_report_type   expected_reports [$];
   int                mismatch_total, checked_total, reject_total, used_peak;

   function automatic void clear_store();
      head_ptr     = '0;
      tail_ptr     = '0;
      fill_ptr     = '0;
      peek_ptr     = '0;
      fill_left    = '0;
      read_left    = '0;
      read_len     = '0;
      peek_left    = '0;
      peek_len     = '0;
      fill_mode    = MODE_IDLE;
      reading      = 1'b0;
      peeking      = 1'b0;
      stored_total = 0;
   endfunction

   function automatic fifo_report_type apply_request(input kind_type kind,
                                                     input logic [BYTE_W-1:0] value,
                                                     input logic [LEN_W-1:0] len);
      fifo_report_type   rep;
      logic [USED_W-1:0] used;
      int                need;
      int                room;
      rep = '0;
      rep.status = ST_OK;
      case (kind)
         KIND_BEGIN: begin
            used = tail_ptr - head_ptr;
            room = RING_BYTES - 1 - used;
            need = len + 2;
            fill_ptr = tail_ptr;
            fill_left = len;
            if (need > room) begin
               rep.status = ST_FULL;
               fill_mode = (len == 0) ? MODE_IDLE : MODE_DROP;
            end else begin
               ring_copy[fill_ptr] = len[15:8];
               fill_ptr = fill_ptr + 1'b1;
               ring_copy[fill_ptr] = len[7:0];
               fill_ptr = fill_ptr + 1'b1;
               if (len == 0) begin
                  tail_ptr = fill_ptr;
                  stored_total++;
                  fill_mode = MODE_IDLE;
               end else begin
                  fill_mode = MODE_FILL;
               end
            end
         end
         KIND_WRITE: begin
            if (fill_mode == MODE_FILL) begin
               ring_copy[fill_ptr] = value;
               fill_ptr = fill_ptr + 1'b1;
               fill_left = fill_left - 1'b1;
               if (fill_left == 0) begin
                  tail_ptr = fill_ptr;
                  stored_total++;
                  fill_mode = MODE_IDLE;
               end
            end else begin
               rep.status = ST_FULL;
               if (fill_mode == MODE_DROP) begin
                  fill_left = fill_left - 1'b1;
                  if (fill_left == 0) fill_mode = MODE_IDLE;
               end
            end
         end
         KIND_READ: begin
            peeking = 1'b0;
            if (!reading && stored_total == 0) begin
               rep.status = ST_EMPTY;
            end else begin
               if (!reading) begin
                  read_len = {ring_copy[head_ptr], ring_copy[head_ptr + 1'b1]};
                  head_ptr = head_ptr + 2'd2;
                  read_left = read_len;
                  reading = 1'b1;
               end
               rep.length = read_len;
               if (read_left != 0) begin
                  rep.byte_out = ring_copy[head_ptr];
                  head_ptr = head_ptr + 1'b1;
                  read_left = read_left - 1'b1;
               end
               if (read_left == 0) begin
                  rep.eom = 1'b1;
                  reading = 1'b0;
                  stored_total--;
               end
            end
         end
         KIND_PEEK: begin
            if (!peeking && !reading && stored_total == 0) begin
               rep.status = ST_EMPTY;
            end else begin
               if (!peeking) begin
                  // A peek that starts in the middle of a read walks the unread rest.
                  if (reading) begin
                     peek_len  = read_len;
                     peek_left = read_left;
                     peek_ptr  = head_ptr;
                  end else begin
                     peek_len  = {ring_copy[head_ptr], ring_copy[head_ptr + 1'b1]};
                     peek_left = peek_len;
                     peek_ptr  = head_ptr + 2'd2;
                  end
                  peeking = 1'b1;
               end
               rep.length = peek_len;
               if (peek_left != 0) begin
                  rep.byte_out = ring_copy[peek_ptr];
                  peek_ptr = peek_ptr + 1'b1;
                  peek_left = peek_left - 1'b1;
               end
               if (peek_left == 0) begin
                  rep.eom = 1'b1;
                  peeking = 1'b0;
               end
            end
         end
         KIND_FLUSH: clear_store();
         default: ;
      endcase
      used = tail_ptr - head_ptr;
      rep.used = used;
      rep.free = USED_W'((RING_BYTES - 1) - used);
      rep.count = COUNT_W'(stored_total);
      return rep;
   endfunction

   always @(posedge clock) begin
      fifo_report_type want;
      fifo_report_type predicted;
      if (reset) begin
         clear_store();
         expected_reports.delete();
      end else begin
         // Results are compared before new requests are predicted, since a request
         // can never produce its own result at the edge where it is accepted.
         if (rsp_valid) begin
            checked_total++;
            if (expected_reports.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: result with no request outstanding", $realtime);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_status !== want.status || rsp_byte_out !== want.byte_out ||
                   rsp_length_out !== want.length || rsp_end_of_message !== want.eom ||
                   rsp_used_bytes !== want.used || rsp_free_bytes !== want.free ||
                   rsp_message_count !== want.count) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("%0t: expected status=%0d byte=%02h len=%0d eom=%0d",
                              $realtime, want.status, want.byte_out, want.length, want.eom,
                              " used=%0d free=%0d count=%0d", want.used, want.free,
                              want.count);
                     $display("%0t:      got status=%0d byte=%02h len=%0d eom=%0d",
                              $realtime, rsp_status, rsp_byte_out, rsp_length_out,
                              rsp_end_of_message, " used=%0d free=%0d count=%0d",
                              rsp_used_bytes, rsp_free_bytes, rsp_message_count);
                  end
               end
            end
         end
         if (start && !busy) begin
            predicted = apply_request(req_kind, req_data_byte, req_msg_length);
            if (req_kind == KIND_BEGIN && predicted.status == ST_FULL) reject_total++;
            if (predicted.used > used_peak) used_peak = predicted.used;
            expected_reports.push_back(predicted);
         end
      end
      failures        <= mismatch_total;
      outstanding     <= expected_reports.size();
      results_checked <= checked_total;
      rejects_seen    <= reject_total;
      peak_used       <= used_peak;
   end

endmodule

/* tb/length_prefixed_message_fifo_test.sv */
// Testbench top for the length-prefixed message FIFO: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module length_prefixed_message_fifo_test;
   import lpmf_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RING_BYTES      = 1024;
   localparam int RANDOM_REQUESTS = 1650;
   localparam int IDLE_PERCENT    = 32;
   localparam int DRAIN_CYCLES    = 8;
   // About 1700 requests plus their idle gaps end long before this limit,
   // which leaves a wide margin.
   localparam int CYCLE_LIMIT     = 200000;

   // Kinds past flush are decoded by the block as no-ops.
   localparam kind_type KIND_UNUSED_LO = 3'd5;
   localparam kind_type KIND_UNUSED_HI = 3'd7;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [KIND_W-1:0]   req_kind       = '0;
   logic [BYTE_W-1:0]   req_data_byte  = '0;
   logic [LEN_W-1:0]    req_msg_length = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_byte_out;
   logic [LEN_W-1:0]    rsp_length_out;
   logic                rsp_end_of_message;
   logic [USED_W-1:0]   rsp_used_bytes;
   logic [USED_W-1:0]   rsp_free_bytes;
   logic [COUNT_W-1:0]  rsp_message_count;

   int failures, outstanding, results_checked, rejects_seen, peak_used;

   // Request bookkeeping. Every request gives exactly one result, so the number
   // of requests sent is also the number of results the end of the run waits for.
   int   sent_by_kind [8];
   int   total_sent;
   int   real_requests;
   int   cycle_count;
   logic idling_on = 1'b1;

   length_prefixed_message_fifo #(
      .RING_BYTES(RING_BYTES)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .req_msg_length     (req_msg_length),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_length_out     (rsp_length_out),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_used_bytes     (rsp_used_bytes),
      .rsp_free_bytes     (rsp_free_bytes),
      .rsp_message_count  (rsp_message_count)
   );

   length_prefixed_message_fifo_check #(
      .RING_BYTES(RING_BYTES)
   ) u_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .req_msg_length     (req_msg_length),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_length_out     (rsp_length_out),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_used_bytes     (rsp_used_bytes),
      .rsp_free_bytes     (rsp_free_bytes),
      .rsp_message_count  (rsp_message_count),
      .failures           (failures),
      .outstanding        (outstanding),
      .results_checked    (results_checked),
      .rejects_seen       (rejects_seen),
      .peak_used          (peak_used)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, outstanding);
      $display("== FAIL ==");
      $finish;
   end

   // Sends one request. Before it, the sender may sit idle for a random number
   // of cycles with start low. The request then stays on the ports until an edge
   // finds busy low, which is the edge where the block takes it. All drives are
   // nonblocking at the rising edge, and start is assigned at most once per step.
   task automatic send_request(input kind_type kind, input logic [BYTE_W-1:0] value,
                               input logic [LEN_W-1:0] len);
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_kind       <= kind;
      req_data_byte  <= value;
      req_msg_length <= len;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_by_kind[kind]++;
      total_sent++;
      if (kind <= KIND_FLUSH) real_requests++;
   endtask

   initial begin
      int       len;
      int       body;
      int       sel;
      int       pick;
      int       random_base;
      int       random_sent;
      logic     filling;
      kind_type kind;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The store starts empty, so reads and peeks report empty
      // and a write byte with no message open is dropped. Unused kinds must
      // change nothing.
      send_request(KIND_READ, 8'h00, 16'h0000);
      send_request(KIND_PEEK, 8'h00, 16'h0000);
      send_request(KIND_WRITE, 8'hFF, 16'hFFFF);
      send_request(KIND_UNUSED_LO, 8'hFF, 16'hFFFF);
      send_request(KIND_UNUSED_HI, 8'h00, 16'h0000);

      // A zero-length message commits at once; peeking and reading it give a
      // zero byte with the end mark set.
      send_request(KIND_BEGIN, 8'h00, 16'h0000);
      send_request(KIND_PEEK, 8'h00, 16'h0000);
      send_request(KIND_READ, 8'h00, 16'h0000);

      // A three-byte message. The first peek starts a walk, the read then stops
      // it, and the next peek walks the unread rest of the message being read.
      send_request(KIND_BEGIN, 8'h00, 16'd3);
      send_request(KIND_WRITE, 8'h00, 16'h0000);
      send_request(KIND_WRITE, 8'hFF, 16'h0000);
      send_request(KIND_WRITE, 8'hA5, 16'h0000);
      send_request(KIND_PEEK, 8'h00, 16'h0000);
      send_request(KIND_READ, 8'h00, 16'h0000);
      send_request(KIND_PEEK, 8'h00, 16'h0000);
      send_request(KIND_PEEK, 8'h00, 16'h0000);
      send_request(KIND_READ, 8'h00, 16'h0000);
      send_request(KIND_READ, 8'h00, 16'h0000);

      // Length boundaries on an empty ring: 1021 payload bytes plus the header
      // fill every usable slot, one more is rejected. The second begin abandons
      // the open message, and the byte after the reject is dropped. The largest
      // length is rejected too, and a flush clears the abandoned state.
      send_request(KIND_BEGIN, 8'h00, 16'd1021);
      send_request(KIND_WRITE, 8'h5A, 16'h0000);
      send_request(KIND_BEGIN, 8'h00, 16'd1022);
      send_request(KIND_WRITE, 8'h11, 16'h0000);
      send_request(KIND_BEGIN, 8'h00, 16'hFFFF);
      send_request(KIND_FLUSH, 8'hFF, 16'hFFFF);

      // Random part. It runs in phases: a long filling phase that mostly writes
      // whole messages, so the ring wraps and reaches full, then a draining
      // phase of reads and peeks, then filling again so rejects and dropped
      // bytes show up. A stretch in the middle runs with no idle cycles at all.
      random_base = real_requests;
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         idling_on = !(random_sent >= 500 && random_sent < 850);
         filling = (random_sent < 1000) || (random_sent >= 1250);
         pick = $urandom_range(99);
         if (pick < (filling ? 85 : 15)) begin
            // One message: mostly short ones, some zero length, a few long or
            // oversized. Most are written out exactly; some are cut short and
            // later abandoned, and some get stray bytes after they complete.
            sel = $urandom_range(99);
            if (sel < 15) len = 0;
            else if (sel < 65) len = $urandom_range(1, 12);
            else if (sel < 87) len = $urandom_range(13, 60);
            else if (sel < 95) len = $urandom_range(61, 250);
            else len = $urandom_range(251, 65535);
            body = len;
            sel = $urandom_range(99);
            if (len > 250 || sel < 8) body = $urandom_range(0, (len < 40) ? len : 40);
            else if (sel < 13) body = len + $urandom_range(1, 3);
            send_request(KIND_BEGIN, 8'($urandom), 16'(len));
            repeat (body) send_request(KIND_WRITE, 8'($urandom), 16'($urandom));
         end else if (pick < (filling ? 85 : 60)) begin
            repeat ($urandom_range(1, 24))
               send_request(KIND_READ, 8'($urandom), 16'($urandom));
         end else if (pick < 94) begin
            // Peeks with the odd read mixed in, which stops the walk under way.
            repeat ($urandom_range(1, 24)) begin
               kind = ($urandom_range(9) == 0) ? KIND_READ : KIND_PEEK;
               send_request(kind, 8'($urandom), 16'($urandom));
            end
         end else begin
            // Noise: any kind with random fields. Flush is kept rare so that it
            // does not undo the filling phases.
            kind = kind_type'($urandom_range(0, 7));
            if (kind == KIND_FLUSH && $urandom_range(7) != 0) kind = KIND_PEEK;
            send_request(kind, 8'($urandom), 16'($urandom));
         end
         random_sent = real_requests - random_base;
      end
      idling_on = 1'b1;
      start <= 1'b0;

      // Wait for the result of every request, then a few cycles more so that a
      // stray extra result would still be caught.
      wait (results_checked >= total_sent);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d begins (%0d rejected), %0d writes, %0d reads,",
               total_sent, sent_by_kind[KIND_BEGIN], rejects_seen,
               sent_by_kind[KIND_WRITE], sent_by_kind[KIND_READ],
               " %0d peeks, %0d flushes, %0d of unused kinds.", sent_by_kind[KIND_PEEK],
               sent_by_kind[KIND_FLUSH], total_sent - real_requests);
      $display("Checked %0d results; the ring held at most %0d of %0d usable bytes.",
               results_checked, peak_used, RING_BYTES - 1);
      if (failures == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
design/lpmf_pkg.sv
design/length_prefixed_message_fifo.sv
tb/length_prefixed_message_fifo_check.sv
tb/length_prefixed_message_fifo_test.sv
